/* design/lrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU tracker package
// Shared widths, defaults, controller state codes and command/status structs.
// ----------------------------------------------------------------------------
package lrt_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int PAGE_W          = 32;
   localparam int CAP_W           = 5;
   localparam int OCC_W           = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOOK = 3'b010,
      S_UPD  = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

/* design/lrt_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU tracker request channel
// Valid/ready channel carrying one page access per beat.
// ----------------------------------------------------------------------------
interface lrt_req_if;
   logic                       valid;
   logic                       ready;
   logic [lrt_pkg::PAGE_W-1:0] page_id;

   modport source (output valid, output page_id, input ready);
   modport sink   (input valid, input page_id, output ready);
endinterface

/* design/lrt_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU tracker response channel
// Valid/ready channel carrying one access result per beat.
// ----------------------------------------------------------------------------
interface lrt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       hit;
   logic                       evicted;
   logic [lrt_pkg::PAGE_W-1:0] evicted_page;
   logic [lrt_pkg::OCC_W-1:0]  occupancy;

   modport source (output valid, output hit, output evicted, output evicted_page,
                   output occupancy, input ready);
   modport sink   (input valid, input hit, input evicted, input evicted_page,
                   input occupancy, output ready);
endinterface

/* design/lrt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU tracker controller
// Sequences capture, lookup and update of one access at a time.
// ----------------------------------------------------------------------------
module lrt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lrt_pkg::sts_type  sts,
   output lrt_pkg::cmd_type  cmd
);

   lrt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.update  = 1'b0;
      unique case (state_ff)
         lrt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = lrt_pkg::S_LOOK;
            end
         end
         lrt_pkg::S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = lrt_pkg::S_UPD;
         end
         lrt_pkg::S_UPD: begin
            if (!sts.out_busy) begin
               cmd.update = 1'b1;
               state_in   = lrt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lrt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* design/lrt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU tracker datapath
// Page keys, recency ranks, parallel match, victim search and result register.
// ----------------------------------------------------------------------------
module lrt_dp #(
   parameter int MAX_ENTRIES = lrt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [lrt_pkg::CAP_W-1:0]  csr_wr_data,
   input  logic [lrt_pkg::PAGE_W-1:0] req_page_id,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic                       rsp_evicted,
   output logic [lrt_pkg::PAGE_W-1:0] rsp_evicted_page,
   output logic [lrt_pkg::OCC_W-1:0]  rsp_occupancy,
   input  lrt_pkg::cmd_type           cmd,
   output lrt_pkg::sts_type           sts
);

   localparam int RW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNW = $clog2(MAX_ENTRIES + 1);
   localparam int CW  = (CNW > lrt_pkg::CAP_W) ? CNW : lrt_pkg::CAP_W;

   logic [lrt_pkg::PAGE_W-1:0] keys_ff [MAX_ENTRIES];
   logic [lrt_pkg::PAGE_W-1:0] keys_in [MAX_ENTRIES];
   logic [RW-1:0]              rank_ff [MAX_ENTRIES];
   logic [RW-1:0]              rank_in [MAX_ENTRIES];
   logic [CW-1:0]              held_ff, held_in;
   logic [lrt_pkg::CAP_W-1:0]  cap_ff;
   logic [lrt_pkg::PAGE_W-1:0] page_ff;

   logic                       found_ff, found_in;
   logic                       free_ff, free_in;
   logic [RW-1:0]              match_ff, match_in;
   logic [RW-1:0]              victim_ff, victim_in;

   logic                       valid_ff, hit_ff, ev_ff;
   logic                       hit_in, ev_in;
   logic [lrt_pkg::PAGE_W-1:0] evp_ff, evp_in;
   logic [lrt_pkg::OCC_W-1:0]  occ_ff;

   logic [CW-1:0]              cap_w, eff_cap;
   logic [RW-1:0]              oldest;
   logic [RW-1:0]              match_rank;

   // Effective capacity and lookup over the held slots.
   always_comb begin
      cap_w = CW'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (cap_w > CW'(MAX_ENTRIES)) begin
         eff_cap = CW'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_w;
      end
      free_in   = held_ff < eff_cap;
      oldest    = RW'(held_ff - CW'(1));
      found_in  = 1'b0;
      match_in  = '0;
      victim_in = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if ((CW'(i) < held_ff) && (keys_ff[i] == page_ff)) begin
            found_in = 1'b1;
            match_in = RW'(i);
         end
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if ((CW'(i) < held_ff) && (rank_ff[i] == oldest)) begin
            victim_in = RW'(i);
         end
      end
   end

   // State update for the captured access.
   always_comb begin
      keys_in    = keys_ff;
      rank_in    = rank_ff;
      held_in    = held_ff;
      hit_in     = 1'b0;
      ev_in      = 1'b0;
      evp_in     = '0;
      match_rank = rank_ff[match_ff];
      if (found_ff) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((CW'(i) < held_ff) && (rank_ff[i] < match_rank)) begin
               rank_in[i] = rank_ff[i] + RW'(1);
            end
         end
         rank_in[match_ff] = '0;
         hit_in            = 1'b1;
      end else if (free_ff) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CW'(i) < held_ff) begin
               rank_in[i] = rank_ff[i] + RW'(1);
            end
         end
         keys_in[held_ff[RW-1:0]] = page_ff;
         rank_in[held_ff[RW-1:0]] = '0;
         held_in                  = held_ff + CW'(1);
      end else begin
         ev_in  = 1'b1;
         evp_in = keys_ff[victim_ff];
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((CW'(i) < held_ff) && (RW'(i) != victim_ff)) begin
               rank_in[i] = rank_ff[i] + RW'(1);
            end
         end
         keys_in[victim_ff] = page_ff;
         rank_in[victim_ff] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
         held_ff  <= '0;
         cap_ff   <= lrt_pkg::CAP_RESET;
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.update) begin
            rank_ff  <= rank_in;
            held_ff  <= held_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff <= req_page_id;
      end
      if (cmd.lookup) begin
         found_ff  <= found_in;
         free_ff   <= free_in;
         match_ff  <= match_in;
         victim_ff <= victim_in;
      end
      if (cmd.update) begin
         keys_ff <= keys_in;
         hit_ff  <= hit_in;
         ev_ff   <= ev_in;
         evp_ff  <= evp_in;
         occ_ff  <= held_in[lrt_pkg::OCC_W-1:0];
      end
   end

   assign sts.out_busy     = valid_ff & ~rsp_ready;
   assign rsp_valid        = valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_evicted      = ev_ff;
   assign rsp_evicted_page = evp_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

/* design/lru_replacement_tracker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU replacement tracker
// Fully associative page tracker with least recently used replacement.
//
//   Channel   Direction  Contents
//   req_ch    in         page_id
//   rsp_ch    out        hit, evicted, evicted_page, occupancy
//   csr_*     in         capacity write (no read-back)
//
// Each request beat passes capture, a parallel match and victim search over the
// held entries, then the rank and key update, in that order.
// A new request is taken while the previous response beat still waits; the
// update cycle waits only while that response is not yet taken.
// Reset is synchronous; it clears ranks, the held count and the response valid flag.
// ----------------------------------------------------------------------------
module lru_replacement_tracker_top #(
   parameter int MAX_ENTRIES = lrt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   lrt_req_if.sink                   req_ch,
   lrt_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [lrt_pkg::CAP_W-1:0] csr_wr_data
);

   lrt_pkg::cmd_type cmd;
   lrt_pkg::sts_type sts;

   lrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrt_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_page_id      (req_ch.page_id),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_hit          (rsp_ch.hit),
      .rsp_evicted      (rsp_ch.evicted),
      .rsp_evicted_page (rsp_ch.evicted_page),
      .rsp_occupancy    (rsp_ch.occupancy),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

/* design/lrt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU tracker port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module lrt_checker #(
   parameter int MAX_ENTRIES = lrt_pkg::MAX_ENTRIES_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_hit,
   input logic                       rsp_evicted,
   input logic [lrt_pkg::PAGE_W-1:0] rsp_evicted_page,
   input logic [lrt_pkg::OCC_W-1:0]  rsp_occupancy
);

   localparam int OCC_CAP = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_evicted_page)
         && $stable(rsp_occupancy))
      else $error("Stalled response beat changed.");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("Response reports both a hit and an eviction.");

   a_evp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_page == '0)
      else $error("Evicted page is non-zero without an eviction.");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy != '0)
         && (MAX_ENTRIES > 31 || rsp_occupancy <= lrt_pkg::OCC_W'(OCC_CAP)))
      else $error("Occupancy outside the built entry range.");

endmodule

bind lru_replacement_tracker_top lrt_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_lrt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_hit          (rsp_ch.hit),
   .rsp_evicted      (rsp_ch.evicted),
   .rsp_evicted_page (rsp_ch.evicted_page),
   .rsp_occupancy    (rsp_ch.occupancy)
);

/* test/tb_lru_replacement_tracker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU replacement tracker testbench
// Drives page accesses through the request channel under random gaps and
// checks every response beat against a behavioural tracker of held pages,
// recency ranks and occupancy. The capacity register is rewritten between
// phases, including the out-of-range values and lowering below occupancy.
// ----------------------------------------------------------------------------
module tb_lru_replacement_tracker_top;

   localparam int ENTRIES        = lrt_pkg::MAX_ENTRIES_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 300;

   typedef struct packed {
      logic                       hit;
      logic                       evicted;
      logic [lrt_pkg::PAGE_W-1:0] evicted_page;
      logic [lrt_pkg::OCC_W-1:0]  occupancy;
   } access_result_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [lrt_pkg::CAP_W-1:0] csr_wr_data;

   lrt_req_if req_if ();
   lrt_rsp_if rsp_if ();

   lru_replacement_tracker_top #(.MAX_ENTRIES(ENTRIES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Tracker state mirrored by the testbench.
   logic [lrt_pkg::PAGE_W-1:0] page_keys [ENTRIES];
   int                         page_rank [ENTRIES];
   int                         held_pages;
   logic [lrt_pkg::CAP_W-1:0]  cap_setting;

   logic [lrt_pkg::PAGE_W-1:0] page_queue [$];
   access_result_type          expected_results [$];
   int                         pages_queued;
   int                         pages_accepted;
   int                         results_seen;
   int                         fail_count;
   int                         src_gap;
   int                         snk_gap;
   int                         hold_left;
   int                         stall_cycles;
   bit                         src_idle_on;
   bit                         snk_idle_on;

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic access_result_type track_access(
      input logic [lrt_pkg::PAGE_W-1:0] page
   );
      access_result_type res;
      int                n;
      int                match;
      int                limit;
      int                victim;
      int                oldest;
      bit                found;
      res   = '0;
      n     = held_pages;
      match = 0;
      found = 1'b0;
      limit = (cap_setting == 0) ? 1 : ((cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting));
      for (int i = 0; i < n; i++) begin
         if (!found && page_keys[i] == page) begin
            found = 1'b1;
            match = i;
         end
      end
      if (found) begin
         for (int i = 0; i < n; i++) begin
            if (page_rank[i] < page_rank[match]) page_rank[i]++;
         end
         page_rank[match] = 0;
         res.hit = 1'b1;
      end else if (n < limit) begin
         for (int i = 0; i < n; i++) page_rank[i]++;
         page_keys[n] = page;
         page_rank[n] = 0;
         n++;
      end else begin
         victim = 0;
         oldest = n - 1;
         for (int i = 0; i < n; i++) begin
            if (page_rank[i] == oldest) victim = i;
         end
         res.evicted      = 1'b1;
         res.evicted_page = page_keys[victim];
         for (int i = 0; i < n; i++) begin
            if (i != victim) page_rank[i]++;
         end
         page_keys[victim] = page;
         page_rank[victim] = 0;
      end
      held_pages    = n;
      res.occupancy = n[lrt_pkg::OCC_W-1:0];
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(track_access(req_if.page_id));
            pages_accepted++;
            src_gap = src_idle_on ? draw_gap() : 0;
         end
         if (!req_if.valid || req_if.ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_if.valid <= 1'b0;
            end else if (page_queue.size() > 0) begin
               req_if.valid   <= 1'b1;
               req_if.page_id <= page_queue.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin : rsp_monitor
      access_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $error("response beat arrived with no access outstanding");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_if.hit);
                  fail_count++;
               end
               if (rsp_if.evicted !== want.evicted) begin
                  $error("evicted: expected %0d, got %0d", want.evicted, rsp_if.evicted);
                  fail_count++;
               end
               if (rsp_if.evicted_page !== want.evicted_page) begin
                  $error("evicted_page: expected %h, got %h",
                         want.evicted_page, rsp_if.evicted_page);
                  fail_count++;
               end
               if (rsp_if.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         want.occupancy, rsp_if.occupancy);
                  fail_count++;
               end
            end
            results_seen++;
            snk_gap = snk_idle_on ? draw_gap() : 0;
            // A long hold-off keeps the response beat waiting and stalls the tracker's input.
            if (results_seen == 400 || results_seen == 1300) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (snk_gap > 0) begin
            snk_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pages_accepted != pages_queued || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [lrt_pkg::CAP_W-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_setting = value;
      @(negedge clock);
   endtask

   task automatic queue_page(input logic [lrt_pkg::PAGE_W-1:0] page);
      page_queue.push_back(page);
      pages_queued++;
   endtask

   task automatic random_phase(input logic [lrt_pkg::CAP_W-1:0] cap, input int count,
                               input bit src_on, input bit snk_on);
      logic [lrt_pkg::PAGE_W-1:0] pool [$];
      logic [lrt_pkg::PAGE_W-1:0] last_page;
      int                         pool_n;
      int                         r;
      write_capacity(cap);
      src_idle_on = src_on;
      snk_idle_on = snk_on;
      pool_n      = 4 + $urandom_range(0, 20);
      for (int i = 0; i < pool_n; i++) pool.push_back($urandom());
      last_page = pool[0];
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 10) last_page = $urandom();
         else if (r >= 20) last_page = pool[$urandom_range(0, pool_n - 1)];
         queue_page(last_page);
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.page_id = '0;
      rsp_if.ready   = 1'b0;
      held_pages     = 0;
      cap_setting    = lrt_pkg::CAP_RESET;
      pages_queued   = 0;
      pages_accepted = 0;
      results_seen   = 0;
      fail_count     = 0;
      src_gap        = 0;
      snk_gap        = 0;
      hold_left      = 0;
      stall_cycles   = 0;
      src_idle_on    = 1'b0;
      snk_idle_on    = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         page_keys[i] = '0;
         page_rank[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single entry: after the first fill, every miss overwrites it in place.
      write_capacity(5'd1);
      queue_page(32'h0000_0000);
      queue_page(32'hFFFF_FFFF);
      queue_page(32'hFFFF_FFFF);
      queue_page(32'h0000_0005);
      // A capacity of zero behaves as one.
      write_capacity(5'd0);
      queue_page(32'h0000_0007);
      queue_page(32'h0000_0007);
      write_capacity(5'd3);
      queue_page(32'h0000_0001);
      queue_page(32'h0000_0002);
      queue_page(32'h0000_0007);
      queue_page(32'h0000_0003);
      queue_page(32'h0000_0002);
      queue_page(32'h0000_0008);
      // Capacity lowered below occupancy: misses replace, nothing is dropped.
      write_capacity(5'd2);
      queue_page(32'h0000_0009);
      queue_page(32'h0000_0003);
      queue_page(32'h0000_000A);
      // Values above the built entry count behave as the full count.
      write_capacity(5'd31);
      queue_page(32'h8000_0000);
      queue_page(32'h7FFF_FFFF);
      queue_page(32'hAAAA_AAAA);
      queue_page(32'h5555_5555);
      queue_page(32'h0000_0001);

      random_phase(5'd12, 175, 1'b0, 1'b0);
      random_phase(5'd16, 175, 1'b1, 1'b1);
      random_phase(5'd5,  175, 1'b1, 1'b0);
      random_phase(5'd1,  175, 1'b0, 1'b1);
      random_phase(5'd0,  175, 1'b1, 1'b1);
      random_phase(5'd31, 175, 1'b1, 1'b1);
      random_phase(5'd9,  175, 1'b0, 1'b0);
      for (int p = 0; p < 3; p++) begin
         random_phase(5'($urandom_range(0, 31)), 175, 1'($urandom_range(0, 1)), 1'b1);
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* lru_replacement_tracker_top.f */
design/lrt_pkg.sv
design/lrt_req_if.sv
design/lrt_rsp_if.sv
design/lrt_ctrl.sv
design/lrt_dp.sv
design/lru_replacement_tracker_top.sv
design/lrt_checker.sv
test/tb_lru_replacement_tracker_top.sv
